### src/tii_pkg.sv
`default_nettype none
package tii_pkg;

  localparam int unsigned DefMaxPoints = 64;
  localparam int unsigned DefFracBits  = 16;

  // shared multiply-divide operand widths
  localparam int unsigned OpW   = 36;
  localparam int unsigned DivW  = 33;
  localparam int unsigned ProdW = 2 * OpW;
  localparam int unsigned QW    = 64;

  localparam logic [2:0] STAT_OK     = 3'd0;
  localparam logic [2:0] STAT_BELOW  = 3'd1;
  localparam logic [2:0] STAT_BEYOND = 3'd2;
  localparam logic [2:0] STAT_ZERO   = 3'd3;
  localparam logic [2:0] STAT_SAT    = 3'd4;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  localparam logic OP_LOAD = 1'b0;

  // shift: skip the divide, scale the product down by 2^(FRAC_BITS+1)
  typedef struct packed {
    logic                   start;
    logic                   shift;
    logic signed [OpW-1:0]  a;
    logic signed [OpW-1:0]  b;
    logic        [DivW-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [QW-1:0] q;
  } md_rsp_t;

endpackage
`default_nettype wire

### src/tii_table.sv
`default_nettype none
module tii_table
  import tii_pkg::*;
#(
  parameter int unsigned MAX_POINTS = DefMaxPoints,
  parameter int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic signed [31:0]   wtime_i,
  input  wire logic signed [31:0]   wval_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic signed [31:0]        rtime_o,
  output logic signed [31:0]        rval_o
);

  logic [31:0] time_mem [MAX_POINTS];
  logic [31:0] val_mem  [MAX_POINTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      time_mem[waddr_i] <= wtime_i;
      val_mem[waddr_i]  <= wval_i;
    end
    rtime_o <= time_mem[raddr_i];
    rval_o  <= val_mem[raddr_i];
  end

endmodule
`default_nettype wire

### src/tii_muldiv.sv
`default_nettype none
module tii_muldiv
  import tii_pkg::*;
#(
  parameter int unsigned FRAC_BITS = DefFracBits
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire md_req_t req_i,
  output md_rsp_t      rsp_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]       ph_q, ph_d;
  logic [6:0]       cnt_q, cnt_d;
  logic [ProdW-1:0] ma_q, ma_d, pr_q, pr_d;
  logic [OpW-1:0]   mb_q, mb_d;
  logic [DivW:0]    rem_q, rem_d;
  logic [DivW-1:0]  dv_q, dv_d;
  logic             neg_q, neg_d;
  logic             sh_q, sh_d;

  logic [OpW-1:0]   amag, bmag;
  logic [DivW+1:0]  rsh;
  logic [QW-1:0]    qmag;
  logic [ProdW-1:0] pr_add;

  assign amag   = req_i.a[OpW-1] ? OpW'(-req_i.a) : OpW'(req_i.a);
  assign bmag   = req_i.b[OpW-1] ? OpW'(-req_i.b) : OpW'(req_i.b);
  assign rsh    = {rem_q, pr_q[ProdW-1]};
  assign qmag   = pr_q[QW-1:0];
  assign pr_add = mb_q[0] ? pr_q + ma_q : pr_q;

  always_comb begin
    ph_d  = ph_q;
    cnt_d = cnt_q;
    ma_d  = ma_q;
    mb_d  = mb_q;
    pr_d  = pr_q;
    rem_d = rem_q;
    dv_d  = dv_q;
    neg_d = neg_q;
    sh_d  = sh_q;
    unique case (ph_q)
      PH_IDLE: begin
        if (req_i.start) begin
          ma_d  = {{(ProdW-OpW){1'b0}}, amag};
          mb_d  = bmag;
          pr_d  = '0;
          dv_d  = req_i.d;
          neg_d = req_i.a[OpW-1] ^ req_i.b[OpW-1];
          sh_d  = req_i.shift;
          cnt_d = 7'(OpW);
          ph_d  = PH_MUL;
        end
      end
      PH_MUL: begin
        pr_d  = pr_add;
        ma_d  = ma_q << 1;
        mb_d  = mb_q >> 1;
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          if (sh_q) begin
            // truncates the magnitude, so the signed result rounds toward zero
            pr_d = pr_add >> (FRAC_BITS + 1);
            ph_d = PH_DONE;
          end else begin
            cnt_d = 7'(ProdW);
            rem_d = '0;
            ph_d  = PH_DIV;
          end
        end
      end
      PH_DIV: begin
        // restoring divide, quotient bits shift into the product register
        pr_d = {pr_q[ProdW-2:0], 1'b0};
        if (rsh >= {1'b0, dv_q}) begin
          rem_d   = (DivW+1)'(rsh - {1'b0, dv_q});
          pr_d[0] = 1'b1;
        end else begin
          rem_d = rsh[DivW:0];
        end
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) ph_d = PH_DONE;
      end
      PH_DONE: ph_d = PH_IDLE;
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      cnt_q <= '0;
    end else begin
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    pr_q  <= pr_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
    neg_q <= neg_d;
    sh_q  <= sh_d;
  end

  assign rsp_o.done = (ph_q == PH_DONE);
  assign rsp_o.q    = neg_q ? -$signed(qmag) : $signed(qmag);

endmodule
`default_nettype wire

### src/table_interpolate_and_integrate_core.sv
// One word in flight at a time; the next is taken once the result register is free.
// Load word: table written on accept when the index is below MAX_POINTS; result 0, status OK.
// Mode 0 evaluate: search, then one bit-serial multiply-divide pass; a query below the
// first entry or at or beyond the last skips both.
// Mode 1 evaluate: up to P-1 intervals, a partial last one with an extra slope divide.
// Reset (async, active low) clears control, mode to 0, point count to 2; table not cleared.
`default_nettype none
module table_interpolate_and_integrate_core
  import tii_pkg::*;
#(
  parameter int unsigned MAX_POINTS = DefMaxPoints,
  parameter int unsigned FRAC_BITS  = DefFracBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [6:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               opcode_i,
  input  wire logic [5:0]         entry_index_i,
  input  wire logic signed [31:0] sample_time_i,
  input  wire logic signed [31:0] sample_value_i,
  input  wire logic signed [31:0] query_time_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      result_value_o,
  output logic [2:0]              status_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LAST  = 5'd1;  // read last entry
  localparam logic [4:0] S_FIRST = 5'd2;  // last entry data, read entry 0
  localparam logic [4:0] S_START = 5'd3;  // entry 0 data
  localparam logic [4:0] S_SRCH  = 5'd4;
  localparam logic [4:0] S_SCMP  = 5'd5;
  localparam logic [4:0] S_IRD   = 5'd6;
  localparam logic [4:0] S_IWT   = 5'd7;
  localparam logic [4:0] S_MCHK  = 5'd8;
  localparam logic [4:0] S_MSLP  = 5'd9;
  localparam logic [4:0] S_MSWT  = 5'd10;
  localparam logic [4:0] S_MDR   = 5'd11;
  localparam logic [4:0] S_MDWT  = 5'd12;
  localparam logic [4:0] S_MAREA = 5'd13;
  localparam logic [4:0] S_MAWT  = 5'd14;
  localparam logic [4:0] S_SAT   = 5'd15;
  localparam logic [4:0] S_FIN   = 5'd16;

  localparam logic signed [QW-1:0] MaxV = QW'(64'sd2147483647);
  localparam logic signed [QW-1:0] MinV = -QW'(64'sd2147483648);

  logic [4:0]             state_q, state_d;
  logic                   mode_q;
  logic [6:0]             pc_q;
  logic signed [31:0]     t_q, t_d;
  logic [AW-1:0]          lo_q, lo_d, hi_q, hi_d, i_q, i_d;
  logic signed [31:0]     tlo_q, tlo_d, vlo_q, vlo_d, tn_q, tn_d, vn_q, vn_d;
  logic signed [31:0]     dl_q, dl_d, d1_q, d1_d;
  logic signed [OpW-1:0]  dr_q, dr_d;
  logic signed [QW-1:0]   acc_q, acc_d;
  logic                   beyond_q, beyond_d, zero_q, zero_d, sat_q, sat_d;
  logic [2:0]             base_q, base_d;
  logic signed [31:0]     res_q, res_d;
  logic [2:0]             st_q, st_d;
  logic                   ov_q;
  logic signed [31:0]     ores_q;
  logic [2:0]             ost_q;

  logic [CW-1:0]          p_eff;
  logic [AW-1:0]          rd_addr;
  logic signed [31:0]     rt, rv;
  logic                   tbl_we;
  md_req_t                md_req;
  md_rsp_t                md_rsp;

  logic [CW-1:0]          mid_sum;
  logic signed [32:0]     w_n, dv_n, dt_lo, tn_w, dd;
  logic signed [31:0]     right_t;
  logic signed [OpW-1:0]  slope_sum;

  // clamp the entry count to 2..MAX_POINTS
  always_comb begin
    if ({25'b0, pc_q} > 32'(MAX_POINTS)) p_eff = CW'(MAX_POINTS);
    else if (pc_q < 7'd2)                p_eff = CW'(2);
    else                                 p_eff = CW'(pc_q);
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign tbl_we = in_valid_i && in_ready_o && (opcode_i == OP_LOAD) &&
                  ({26'b0, entry_index_i} < 32'(MAX_POINTS));

  tii_table #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(entry_index_i)),
    .wtime_i (sample_time_i),
    .wval_i  (sample_value_i),
    .raddr_i (rd_addr),
    .rtime_o (rt),
    .rval_o  (rv)
  );

  tii_muldiv #(.FRAC_BITS(FRAC_BITS)) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign mid_sum   = CW'(((AW+1)'(lo_q) + (AW+1)'(hi_q)) >> 1);
  assign w_n       = {rt[31], rt} - {tlo_q[31], tlo_q};
  assign dv_n      = {rv[31], rv} - {vlo_q[31], vlo_q};
  assign dt_lo     = {t_q[31], t_q} - {tlo_q[31], tlo_q};
  assign tn_w      = {tn_q[31], tn_q} - {tlo_q[31], tlo_q};
  assign dd        = {d1_q[31], d1_q} - {dl_q[31], dl_q};
  assign right_t   = (tn_q < t_q) ? tn_q : t_q;
  assign slope_sum = OpW'(dl_q) + dr_q;

  always_comb begin
    state_d  = state_q;
    t_d      = t_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    i_d      = i_q;
    tlo_d    = tlo_q;
    vlo_d    = vlo_q;
    tn_d     = tn_q;
    vn_d     = vn_q;
    dl_d     = dl_q;
    d1_d     = d1_q;
    dr_d     = dr_q;
    acc_d    = acc_q;
    beyond_d = beyond_q;
    zero_d   = zero_q;
    sat_d    = sat_q;
    base_d   = base_q;
    res_d    = res_q;
    st_d     = st_q;
    rd_addr  = '0;
    md_req   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          t_d    = query_time_i;
          zero_d = 1'b0;
          sat_d  = 1'b0;
          if (opcode_i == OP_LOAD) begin
            res_d   = '0;
            st_d    = STAT_OK;
            state_d = S_FIN;
          end else begin
            state_d = S_LAST;
          end
        end
      end
      S_LAST: begin
        rd_addr = AW'(p_eff - CW'(1));
        state_d = S_FIRST;
      end
      S_FIRST: begin
        beyond_d = (t_q >= rt);
        if (!mode_q && (t_q >= rt)) begin
          acc_d   = QW'(rv);
          base_d  = STAT_BEYOND;
          state_d = S_SAT;
        end else begin
          rd_addr = '0;
          state_d = S_START;
        end
      end
      S_START: begin
        tlo_d = rt;
        vlo_d = rv;
        lo_d  = '0;
        hi_d  = AW'(p_eff - CW'(1));
        i_d   = '0;
        dl_d  = '0;
        acc_d = QW'(rv);
        if (!mode_q) begin
          base_d  = (t_q < rt) ? STAT_BELOW : STAT_OK;
          state_d = (t_q < rt) ? S_SAT : S_SRCH;
        end else begin
          base_d  = (t_q < rt) ? STAT_BELOW : (beyond_q ? STAT_BEYOND : STAT_OK);
          state_d = S_MCHK;
        end
      end
      // binary search holding T[lo] <= t < T[hi]
      S_SRCH: begin
        if (CW'(hi_q) - CW'(lo_q) > CW'(1)) begin
          rd_addr = AW'(mid_sum);
          state_d = S_SCMP;
        end else begin
          rd_addr = AW'(CW'(lo_q) + CW'(1));
          state_d = S_IRD;
        end
      end
      S_SCMP: begin
        if (t_q < rt) begin
          hi_d = AW'(mid_sum);
        end else begin
          lo_d  = AW'(mid_sum);
          tlo_d = rt;
          vlo_d = rv;
        end
        state_d = S_SRCH;
      end
      S_IRD: begin
        md_req.start = 1'b1;
        md_req.a     = OpW'(dv_n);
        md_req.b     = OpW'(dt_lo);
        md_req.d     = DivW'(w_n);
        state_d      = S_IWT;
      end
      S_IWT: begin
        if (md_rsp.done) begin
          acc_d   = QW'(vlo_q) + md_rsp.q;
          state_d = S_SAT;
        end
      end
      // trapezoid walk over intervals
      S_MCHK: begin
        if ((CW'(i_q) + CW'(1) < p_eff) && (tlo_q < t_q)) begin
          rd_addr = AW'(CW'(i_q) + CW'(1));
          state_d = S_MSLP;
        end else begin
          state_d = S_SAT;
        end
      end
      S_MSLP: begin
        tn_d = rt;
        vn_d = rv;
        if (w_n <= 33'sd0) begin
          zero_d  = 1'b1;
          d1_d    = '0;
          state_d = S_MDR;
        end else begin
          md_req.start = 1'b1;
          md_req.a     = OpW'(dv_n);
          md_req.b     = OpW'(1) <<< FRAC_BITS;
          md_req.d     = DivW'(w_n);
          state_d      = S_MSWT;
        end
      end
      S_MSWT: begin
        if (md_rsp.done) begin
          if (md_rsp.q > MaxV) begin
            d1_d  = 32'sh7fffffff;
            sat_d = 1'b1;
          end else if (md_rsp.q < MinV) begin
            d1_d  = 32'sh80000000;
            sat_d = 1'b1;
          end else begin
            d1_d = 32'(md_rsp.q);
          end
          state_d = S_MDR;
        end
      end
      S_MDR: begin
        if (tn_q < t_q) begin
          dr_d    = OpW'(d1_q);
          state_d = S_MAREA;
        end else begin
          // slope interpolated at a partial right end
          md_req.start = 1'b1;
          md_req.a     = OpW'(dt_lo);
          md_req.b     = OpW'(dd);
          md_req.d     = DivW'(tn_w);
          state_d      = S_MDWT;
        end
      end
      S_MDWT: begin
        if (md_rsp.done) begin
          dr_d    = OpW'(dl_q) + OpW'(md_rsp.q);
          state_d = S_MAREA;
        end
      end
      // width can be negative when the next time steps backward
      S_MAREA: begin
        md_req.start = 1'b1;
        md_req.shift = 1'b1;
        md_req.a     = OpW'($signed({right_t[31], right_t} - {tlo_q[31], tlo_q}));
        md_req.b     = slope_sum;
        state_d      = S_MAWT;
      end
      S_MAWT: begin
        if (md_rsp.done) begin
          acc_d   = acc_q + md_rsp.q;
          i_d     = AW'(CW'(i_q) + CW'(1));
          tlo_d   = tn_q;
          vlo_d   = vn_q;
          dl_d    = d1_q;
          state_d = S_MCHK;
        end
      end
      S_SAT: begin
        if (acc_q > MaxV) begin
          res_d = 32'sh7fffffff;
          st_d  = STAT_SAT;
        end else if (acc_q < MinV) begin
          res_d = 32'sh80000000;
          st_d  = STAT_SAT;
        end else begin
          res_d = 32'(acc_q);
          st_d  = sat_q ? STAT_SAT : (zero_q ? STAT_ZERO : base_q);
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!ov_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= 1'b0;
      pc_q    <= 7'd2;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODE:  mode_q <= cfg_data_i[0];
          CFG_COUNT: pc_q   <= cfg_data_i;
          default:   mode_q <= mode_q;
        endcase
      end
      if (state_q == S_FIN && (!ov_q || out_ready_i)) ov_q <= 1'b1;
      else if (out_ready_i)                           ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    i_q      <= i_d;
    tlo_q    <= tlo_d;
    vlo_q    <= vlo_d;
    tn_q     <= tn_d;
    vn_q     <= vn_d;
    dl_q     <= dl_d;
    d1_q     <= d1_d;
    dr_q     <= dr_d;
    acc_q    <= acc_d;
    beyond_q <= beyond_d;
    zero_q   <= zero_d;
    sat_q    <= sat_d;
    base_q   <= base_d;
    res_q    <= res_d;
    st_q     <= st_d;
    if (state_q == S_FIN && (!ov_q || out_ready_i)) begin
      ores_q <= res_q;
      ost_q  <= st_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign result_value_o = ores_q;
  assign status_o       = ost_q;

endmodule
`default_nettype wire

### src/tii_checker.sv
`default_nettype none
module tii_checker
  import tii_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] result_value_o,
  input wire logic [2:0]  status_o
);

  // a held word keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o) &&
    $stable(status_o))
    else $error("output word changed while stalled");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= STAT_SAT))
    else $error("bad status code");

  // an accepted word, with no result pending, shows no result in the next cycle
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result before work finished");

endmodule

bind table_interpolate_and_integrate_core tii_checker u_tii_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_value_o (result_value_o),
  .status_o       (status_o)
);
`default_nettype wire
